/* rtl/bdd_pkg.sv */
// Shared types and constants for the bounded deque with delete.
package bdd_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_OUT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DELETE     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Broadcast to every cell: which operation, and whether it commits.
    typedef struct packed {
        t_op  op;
        logic go;
    } t_cell_cmd;

endpackage

/* rtl/bounded_deque_with_delete.sv */
// Top level of the bounded deque with delete: cell chain, control and result register.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle for every operation unless a result stalls; delete
// compares all cells at once and shifts the tail in the cycle the item is accepted.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// stored words are not cleared.
module bounded_deque_with_delete
    import bdd_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_W-1:0]     o_popped_value,
    output logic [STATUS_W-1:0]    o_status,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int VAL_EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CNT_EXT_W = (COUNT_W > COUNT_OUT_W) ? COUNT_W : COUNT_OUT_W;

    // Control state
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;

    // Result payload (no reset needed)
    logic [VALUE_W-1:0]     r_popped;
    logic [STATUS_W-1:0]    r_status;
    logic [COUNT_OUT_W-1:0] r_entry_count;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  found;
    t_cell_cmd             cmd;
    t_status               status;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] popped;
    logic [VAL_EXT_W-1:0]  value_ext;
    logic [VAL_EXT_W-1:0]  popped_ext;
    logic [CNT_EXT_W-1:0]  count_ext;

    // Chain wiring: cell data, the "match seen" ripple and the pop-back gather.
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic                  hit_chain [CAPACITY+1];
    logic [DATA_WIDTH-1:0] pop_chain [CAPACITY+1];

    // The output register frees up as soon as the waiting result is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Only the low DATA_WIDTH bits of the value take part.
    assign value_ext = VAL_EXT_W'(i_value);
    assign word      = value_ext[DATA_WIDTH-1:0];

    assign full  = r_count == COUNT_W'(CAPACITY);
    assign empty = r_count == '0;
    assign found = hit_chain[CAPACITY];

    assign hit_chain[0] = 1'b0;
    assign pop_chain[0] = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        // Front cell takes the pushed word on push-front; back cell keeps its own.
        if (k == 0) begin : g_front
            assign left_data = word;
        end else begin : g_mid_l
            assign left_data = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_back
            assign right_data = cell_data[k];
        end else begin : g_mid_r
            assign right_data = cell_data[k+1];
        end

        bdd_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .COUNT_W    (COUNT_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_word       (word),
            .i_count      (r_count),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .i_hit        (hit_chain[k]),
            .o_hit        (hit_chain[k+1]),
            .i_pop        (pop_chain[k]),
            .o_pop        (pop_chain[k+1]),
            .o_data       (cell_data[k])
        );
    end

    // Decode: status, popped word and whether the cells commit the operation.
    always_comb begin
        cmd.op  = t_op'(i_operation);
        cmd.go  = 1'b0;
        status  = ST_OK;
        popped  = '0;
        n_count = r_count;
        unique case (t_op'(i_operation))
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.go  = accept;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.go  = accept;
                    popped  = pop_chain[CAPACITY];
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.go  = accept;
                    popped  = cell_data[0];
                    n_count = r_count - 1'b1;
                end
            end
            OP_DELETE: begin
                if (!found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    cmd.go  = accept;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                // unused codes: no operation
                status = ST_OK;
            end
        endcase
    end

    assign popped_ext = VAL_EXT_W'(popped);
    assign count_ext  = CNT_EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped      <= popped_ext[VALUE_W-1:0];
            r_status      <= status;
            r_entry_count <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = r_entry_count;

endmodule

/* rtl/bdd_cell.sv */
// One storage cell of the deque chain: holds the entry at a fixed logical position.
module bdd_cell
    import bdd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int COUNT_W    = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_hit,
    output logic                  o_hit,
    input  logic [DATA_WIDTH-1:0] i_pop,
    output logic [DATA_WIDTH-1:0] o_pop,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  occ;
    logic                  is_last;
    logic                  is_tail_slot;

    // Occupied cells form a prefix of the chain: position < count.
    assign occ          = i_count > COUNT_W'(INDEX);
    assign is_last      = i_count == COUNT_W'(INDEX + 1);
    assign is_tail_slot = i_count == COUNT_W'(INDEX);

    // Match seen at or in front of this cell.
    assign o_hit = i_hit | (occ && (r_data == i_word));

    assign o_pop = i_pop | (((i_cmd.op == OP_POP_BACK) && is_last) ? r_data : '0);

    always_comb begin
        n_data = r_data;
        if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_PUSH_BACK:  if (is_tail_slot) n_data = i_word;
                OP_PUSH_FRONT: n_data = i_left_data;
                OP_POP_FRONT:  n_data = i_right_data;
                OP_DELETE:     if (o_hit) n_data = i_right_data;
                default:       n_data = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/bdd_checker.sv */
// Port-level checks for the bounded deque with delete, bound to the top level.
module bdd_checker
    import bdd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_W-1:0]     o_popped_value,
    input logic [STATUS_W-1:0]    o_status,
    input logic [COUNT_OUT_W-1:0] o_entry_count
);

    // No result survives reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every accepted item yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item produced no result");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_popped_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result changed");

    // Failed operations return no word; an empty pop reports an empty queue.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_popped_value == '0)
            && (o_entry_count == '0))
        else $error("empty pop reported data or entries");

    a_nonok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_popped_value == '0)
        else $error("failed operation returned a word");

endmodule

bind bounded_deque_with_delete bdd_checker u_bdd_checker (.*);
